// ===== design/sensor_frame_deframer_core_defines.svh =====
// Assertion macros shared by the deframer RTL.
// No dependencies; included by the top level only.
`ifndef SENSOR_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define SENSOR_FRAME_DEFRAMER_CORE_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define SFD_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("sensor frame deframer assertion failed");

// The condition must hold in the cycle after the trigger.
`define SFD_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("sensor frame deframer assertion failed");

`endif

// ===== design/sfd_pkg.sv =====
// Shared types and constants for the sensor frame deframer.
// No dependencies; used by every module of the block.
package sfd_pkg;

   localparam int FRAME_LEN      = 24;
   localparam int DATA_BYTES     = FRAME_LEN - 2;   // bytes 1 .. FRAME_LEN-2
   localparam int NUM_CHAN       = 9;
   localparam int COUNT_WIDTH    = 5;
   localparam int CSR_IDX_WIDTH  = 8;

   localparam logic [COUNT_WIDTH-1:0] TAIL_POS = COUNT_WIDTH'(FRAME_LEN - 1);

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SYNC_BYTE = CSR_IDX_WIDTH'(0);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TAIL_BYTE = CSR_IDX_WIDTH'(1);

   localparam logic [7:0] SYNC_RESET = 8'h40;
   localparam logic [7:0] TAIL_RESET = 8'h0a;

   typedef struct packed {
      logic [7:0] sync_byte;
      logic [7:0] tail_byte;
   } cfg_type;

   typedef struct packed {
      logic [31:0]                 timestamp;
      logic [NUM_CHAN-1:0][15:0]   chan;
   } result_type;

   typedef struct packed {
      logic out_valid;
      logic skid_valid;
   } buf_status_type;

endpackage

// ===== design/sfd_csr.sv =====
// Configuration registers: sync byte and tail byte.
// Depends on sfd_pkg.
module sfd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [sfd_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [7:0]                       csr_data,
   output sfd_pkg::cfg_type                 cfg
);

   sfd_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sfd_pkg::CSR_SYNC_BYTE: cfg_in.sync_byte = csr_data;
            sfd_pkg::CSR_TAIL_BYTE: cfg_in.tail_byte = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_byte <= sfd_pkg::SYNC_RESET;
         cfg_ff.tail_byte <= sfd_pkg::TAIL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/sfd_deframer.sv =====
// Sync hunt, byte counter and frame capture shift line.
// Depends on sfd_pkg.
module sfd_deframer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   input  sfd_pkg::cfg_type     cfg,
   output logic                 res_valid,
   output sfd_pkg::result_type  res
);

   logic                                   hunting_ff, hunting_in;
   logic [sfd_pkg::COUNT_WIDTH-1:0]        count_ff, count_in;
   logic [sfd_pkg::DATA_BYTES-1:0][7:0]    shift_ff, shift_in;

   always_comb begin
      hunting_in = hunting_ff;
      count_in   = count_ff;
      shift_in   = shift_ff;
      res_valid  = 1'b0;
      if (accept) begin
         if (hunting_ff) begin
            // The sync byte itself is never read back, so it is not stored.
            if (rx_byte == cfg.sync_byte) begin
               hunting_in = 1'b0;
               count_in   = sfd_pkg::COUNT_WIDTH'(1);
            end
         end else if (count_ff < sfd_pkg::TAIL_POS) begin
            shift_in = {rx_byte, shift_ff[sfd_pkg::DATA_BYTES-1:1]};
            count_in = count_ff + sfd_pkg::COUNT_WIDTH'(1);
         end else begin
            hunting_in = 1'b1;
            count_in   = '0;
            res_valid  = (rx_byte == cfg.tail_byte);
         end
      end
   end

   // After a full frame, entry 0 holds byte 1 and the last entry holds byte 22.
   always_comb begin
      res.timestamp = {shift_ff[3], shift_ff[2], shift_ff[1], shift_ff[0]};
      for (int k = 0; k < sfd_pkg::NUM_CHAN; k++) begin
         res.chan[k] = {shift_ff[2*k+5], shift_ff[2*k+4]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hunting_ff <= 1'b1;
         count_ff   <= '0;
      end else begin
         hunting_ff <= hunting_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

endmodule

// ===== design/sfd_rsp_buffer.sv =====
// Result register with a one-entry skid stage behind it.
// Depends on sfd_pkg.
module sfd_rsp_buffer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  sfd_pkg::result_type    load_data,
   input  logic                   rsp_stall,
   output sfd_pkg::result_type    out_data,
   output sfd_pkg::buf_status_type status
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   sfd_pkg::result_type  out_ff, out_in;
   sfd_pkg::result_type  skid_ff, skid_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || !rsp_stall) begin
         // Input is stalled while the skid holds a result, so no load then.
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = load_data;
            out_valid_in = load;
         end
      end else if (load) begin
         skid_in       = load_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_data          = out_ff;
   assign status.out_valid  = out_valid_ff;
   assign status.skid_valid = skid_valid_ff;

endmodule

// ===== design/sensor_frame_deframer_core.sv =====
// Sensor frame deframer: takes one received byte per cycle while req_stall is low, hunts
// for the sync byte, collects a 24-byte frame and, when the last byte matches the tail
// byte, delivers the timestamp and nine channel values through the output register.
// Depends on sfd_pkg, sfd_csr, sfd_deframer, sfd_rsp_buffer and the defines header.
//
// A request is accepted whenever req_stall is low, so one byte can enter each clock then.
// A result waits in the output register; one more result fits in a skid stage,
// and req_stall is high only while that skid stage is occupied. Configuration
// writes always complete in the cycle they are presented (csr_ready is high).
`include "sensor_frame_deframer_core_defines.svh"

module sensor_frame_deframer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [31:0]                       rsp_timestamp,
   output logic [15:0]                       rsp_chan_a,
   output logic [15:0]                       rsp_chan_b,
   output logic [15:0]                       rsp_chan_c,
   output logic [15:0]                       rsp_chan_d,
   output logic [15:0]                       rsp_chan_e,
   output logic [15:0]                       rsp_chan_f,
   output logic [15:0]                       rsp_chan_g,
   output logic [15:0]                       rsp_chan_h,
   output logic [15:0]                       rsp_chan_i,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sfd_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [7:0]                        csr_data
);

   sfd_pkg::cfg_type        cfg;
   sfd_pkg::result_type     res;
   sfd_pkg::result_type     out_data;
   sfd_pkg::buf_status_type status;
   logic                    res_valid;
   logic                    req_accept;

   assign csr_ready  = 1'b1;
   assign req_stall  = status.skid_valid;
   assign req_accept = req_valid && !req_stall;

   sfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sfd_deframer u_deframer (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .rx_byte   (req_rx_byte),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   sfd_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res),
      .rsp_stall (rsp_stall),
      .out_data  (out_data),
      .status    (status)
   );

   assign rsp_valid     = status.out_valid;
   assign rsp_timestamp = out_data.timestamp;
   assign rsp_chan_a    = out_data.chan[0];
   assign rsp_chan_b    = out_data.chan[1];
   assign rsp_chan_c    = out_data.chan[2];
   assign rsp_chan_d    = out_data.chan[3];
   assign rsp_chan_e    = out_data.chan[4];
   assign rsp_chan_f    = out_data.chan[5];
   assign rsp_chan_g    = out_data.chan[6];
   assign rsp_chan_h    = out_data.chan[7];
   assign rsp_chan_i    = out_data.chan[8];

   // The skid stage only fills behind an occupied output register.
   `SFD_ASSERT_SAME(a_skid_behind_out, clock, reset, status.skid_valid, status.out_valid)
   // After a good frame, rsp_valid is always high in the following cycle.
   `SFD_ASSERT_NEXT(a_result_visible, clock, reset, res_valid, rsp_valid)
   // When the output is taken, the skid entry moves forward and frees the input.
   `SFD_ASSERT_NEXT(a_skid_drains, clock, reset, status.skid_valid && !rsp_stall,
                    rsp_valid && !req_stall)

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for sensor_frame_deframer_core: streams sync/data/tail byte
// sequences under several sync and tail settings and checks every decoded frame.
// Depends on sfd_pkg and the sensor_frame_deframer_core RTL.
`timescale 1ns / 100ps

module tb;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BYTES   = 290;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AFTER    = 12;

   localparam logic [sfd_pkg::CSR_IDX_WIDTH-1:0] CSR_FIRST_UNUSED =
      sfd_pkg::CSR_TAIL_BYTE + 1'b1;
   localparam logic [sfd_pkg::CSR_IDX_WIDTH-1:0] CSR_IDX_LAST = '1;

   typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_TOGGLE} flow_mode_type;
   typedef enum int {SEQ_GOOD, SEQ_BAD_TAIL, SEQ_NOISE} seq_kind_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [7:0]                        req_rx_byte = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [31:0]                       rsp_timestamp;
   logic [15:0]                       rsp_chan_a, rsp_chan_b, rsp_chan_c, rsp_chan_d;
   logic [15:0]                       rsp_chan_e, rsp_chan_f, rsp_chan_g, rsp_chan_h;
   logic [15:0]                       rsp_chan_i;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [sfd_pkg::CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [7:0]                        csr_data = '0;

   sensor_frame_deframer_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_timestamp(rsp_timestamp),
      .rsp_chan_a(rsp_chan_a), .rsp_chan_b(rsp_chan_b), .rsp_chan_c(rsp_chan_c),
      .rsp_chan_d(rsp_chan_d), .rsp_chan_e(rsp_chan_e), .rsp_chan_f(rsp_chan_f),
      .rsp_chan_g(rsp_chan_g), .rsp_chan_h(rsp_chan_h), .rsp_chan_i(rsp_chan_i),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // Shadow deframer state, updated at each accepted request.
   sfd_pkg::cfg_type                    cur_cfg;
   logic                                hunt_mode;
   logic [sfd_pkg::COUNT_WIDTH-1:0]     frame_pos;
   logic [7:0]                          frame_buf [0:sfd_pkg::FRAME_LEN-2];
   sfd_pkg::result_type                 frames_due [$];
   logic [7:0]                          pending_bytes [$];
   int                                  mismatches = 0;

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
      mismatches++;
   endtask

   task automatic take_byte(input logic [7:0] b);
      sfd_pkg::result_type r;
      if (hunt_mode) begin
         if (b == cur_cfg.sync_byte) begin
            frame_buf[0] = b;
            frame_pos = sfd_pkg::COUNT_WIDTH'(1);
            hunt_mode = 1'b0;
         end
      end else if (frame_pos < sfd_pkg::TAIL_POS) begin
         frame_buf[frame_pos] = b;
         frame_pos = frame_pos + 1'b1;
      end else begin
         hunt_mode = 1'b1;
         frame_pos = '0;
         if (b == cur_cfg.tail_byte) begin
            r.timestamp = {frame_buf[4], frame_buf[3], frame_buf[2], frame_buf[1]};
            for (int k = 0; k < sfd_pkg::NUM_CHAN; k++)
               r.chan[k] = {frame_buf[6 + 2 * k], frame_buf[5 + 2 * k]};
            frames_due.push_back(r);
         end
      end
   endtask

   // Observes both channels and the register port; input side goes first so a byte
   // accepted with a write still sees the old setting.
   always @(posedge clock) begin : monitor
      sfd_pkg::result_type want;
      logic [15:0]         got_chan [0:sfd_pkg::NUM_CHAN-1];
      if (reset) begin
         cur_cfg.sync_byte = sfd_pkg::SYNC_RESET;
         cur_cfg.tail_byte = sfd_pkg::TAIL_RESET;
         hunt_mode = 1'b1;
         frame_pos = '0;
      end else begin
         if (req_valid && !req_stall)
            take_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            if (frames_due.size() == 0) begin
               report_mismatch("unexpected result, timestamp", rsp_timestamp, '0);
            end else begin
               want = frames_due.pop_front();
               got_chan = '{rsp_chan_a, rsp_chan_b, rsp_chan_c, rsp_chan_d, rsp_chan_e,
                            rsp_chan_f, rsp_chan_g, rsp_chan_h, rsp_chan_i};
               if (rsp_timestamp !== want.timestamp)
                  report_mismatch("timestamp", rsp_timestamp, want.timestamp);
               for (int k = 0; k < sfd_pkg::NUM_CHAN; k++)
                  if (got_chan[k] !== want.chan[k])
                     report_mismatch($sformatf("chan_%c", 8'h61 + k), 32'(got_chan[k]),
                                     32'(want.chan[k]));
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == sfd_pkg::CSR_SYNC_BYTE)
               cur_cfg.sync_byte = csr_data;
            else if (csr_index == sfd_pkg::CSR_TAIL_BYTE)
               cur_cfg.tail_byte = csr_data;
         end
      end
   end

   // Byte sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_valid <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
            if (burst_left == 0)
               burst_left = $urandom_range(1, 48);
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: switches among four stall patterns, and once a long hold-off lets
   // results pile up until the block stalls its input.
   flow_mode_type flow_mode = FLOW_FREE;
   int            mode_left = 0;
   int            hold_left = 0;
   int            rsp_taken = 0;
   bit            hold_done = 1'b0;

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            rsp_taken++;
         if (!hold_done && rsp_taken >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               flow_mode = flow_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            case (flow_mode)
               FLOW_FREE:  rsp_stall <= 1'b0;
               FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               FLOW_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:    rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   int quiet_cycles = 0;

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] pick_data();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hff;
         2:       return cur_cfg.sync_byte;
         3:       return cur_cfg.tail_byte;
         default: return 8'($urandom());
      endcase
   endfunction

   task automatic push_frame(input bit good);
      logic [7:0] last;
      pending_bytes.push_back(cur_cfg.sync_byte);
      repeat (sfd_pkg::DATA_BYTES) pending_bytes.push_back(pick_data());
      last = cur_cfg.tail_byte;
      if (!good)
         last = cur_cfg.tail_byte ^ 8'($urandom_range(1, 255));
      pending_bytes.push_back(last);
   endtask

   task automatic push_sequence();
      seq_kind_type kind;
      int           roll;
      roll = $urandom_range(0, 99);
      kind = (roll < 70) ? SEQ_GOOD : (roll < 85) ? SEQ_BAD_TAIL : SEQ_NOISE;
      case (kind)
         SEQ_GOOD:     push_frame(1'b1);
         SEQ_BAD_TAIL: push_frame(1'b0);
         default:      repeat ($urandom_range(1, 6)) pending_bytes.push_back(8'($urandom()));
      endcase
   endtask

   // Sampled at the falling edge so the queues and shadow state are settled.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || frames_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Closes a frame left open at the end of a phase with a wrong tail, so that
   // register writes happen while the block is hunting.
   task automatic close_frame();
      while (!hunt_mode) begin
         repeat (sfd_pkg::FRAME_LEN - frame_pos) pending_bytes.push_back(~cur_cfg.tail_byte);
         wait_idle();
      end
   endtask

   task automatic write_reg(input logic [sfd_pkg::CSR_IDX_WIDTH-1:0] idx,
                            input logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [7:0] shared;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // Directed: noise at both extremes, then a good frame whose payload holds the
      // sync and tail values and both byte extremes.
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hff);
      pending_bytes.push_back(cur_cfg.sync_byte);
      for (int i = 0; i < sfd_pkg::DATA_BYTES; i++)
         case (i % 4)
            0:       pending_bytes.push_back(8'hff);
            1:       pending_bytes.push_back(8'h00);
            2:       pending_bytes.push_back(cur_cfg.sync_byte);
            default: pending_bytes.push_back(cur_cfg.tail_byte);
         endcase
      pending_bytes.push_back(cur_cfg.tail_byte);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: begin
               write_reg(sfd_pkg::CSR_SYNC_BYTE, 8'h00);
               write_reg(sfd_pkg::CSR_TAIL_BYTE, 8'hff);
            end
            2: begin
               write_reg(sfd_pkg::CSR_SYNC_BYTE, 8'hff);
               write_reg(sfd_pkg::CSR_TAIL_BYTE, 8'h00);
            end
            3: begin
               // The tail byte equals the sync byte here.
               shared = 8'($urandom());
               write_reg(sfd_pkg::CSR_SYNC_BYTE, shared);
               write_reg(sfd_pkg::CSR_TAIL_BYTE, shared);
            end
            4: begin
               // Writes to unused indexes must leave both registers alone.
               write_reg(CSR_IDX_LAST, 8'($urandom()));
               write_reg(sfd_pkg::CSR_IDX_WIDTH'($urandom_range(CSR_FIRST_UNUSED,
                                                                 CSR_IDX_LAST - 1)),
                         8'($urandom()));
            end
            5: begin
               write_reg(sfd_pkg::CSR_SYNC_BYTE, 8'($urandom()));
               write_reg(sfd_pkg::CSR_TAIL_BYTE, 8'($urandom()));
            end
            default: ;
         endcase
         @(negedge clock);
         while (pending_bytes.size() < PHASE_BYTES)
            push_sequence();
         wait_idle();
         close_frame();
      end

      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/sfd_pkg.sv
design/sfd_csr.sv
design/sfd_deframer.sv
design/sfd_rsp_buffer.sv
design/sensor_frame_deframer_core.sv
verif/tb.sv
